// ===== rtl/badt_pkg.sv =====
// Shared types and constants for the advertising device table tracker.
package badt_pkg;

  localparam int ADDR_W    = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [7:0] LEVEL_INIT_MAX = -8'sd127;

  localparam logic [CFG_IDX_W-1:0] REG_TRACKING_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd1;

  typedef enum logic [1:0] {
    OP_REPORT    = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_READ_TBL  = 2'd2,
    OP_READ_HIST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_UPDATED  = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_SAMPLE   = 3'd4,
    STAT_CLEARED  = 3'd5,
    STAT_READ_OK  = 3'd6,
    STAT_READ_OOR = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_READ_TBL,
    S_READ_HIST
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [ADDR_W-1:0]  device_address;
    logic signed [7:0]  signal_level;
    logic [1:0]         addr_kind;
    logic [6:0]         read_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [6:0]         entry_index;
    logic [ADDR_W-1:0]  entry_address;
    logic signed [7:0]  entry_level;
    logic [1:0]         entry_kind;
    logic [5:0]         devices_held;
    logic signed [7:0]  current_level;
    logic signed [7:0]  lowest_level;
    logic signed [7:0]  highest_level;
    logic [7:0]         samples_held;
  } out_item_t;

  // per-item part of the result; the statistics are taken live from their registers
  typedef struct packed {
    status_t            status;
    logic [6:0]         entry_index;
    logic [ADDR_W-1:0]  entry_address;
    logic signed [7:0]  entry_level;
    logic [1:0]         entry_kind;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic signed [7:0]  level;
    logic [1:0]         kind;
  } tbl_entry_t;

  typedef struct packed {
    logic               clear;
    logic               sample;
    logic signed [7:0]  level;
  } stats_ctl_t;

  typedef struct packed {
    logic [6:0]         ring_pos;
    logic [7:0]         ring_fill;
    logic signed [7:0]  latest;
    logic signed [7:0]  lowest;
    logic signed [7:0]  highest;
  } stats_t;

endpackage

// ===== rtl/badt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module badt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/badt_history.sv =====
// Target RSSI history ring and min/max/current tracking statistics.
module badt_history #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  badt_pkg::stats_ctl_t             ctl,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
  output logic signed [7:0]                rd_level,
  output badt_pkg::stats_t                 stats
);

  localparam int HIDX_W  = $clog2(HISTORY_DEPTH);
  localparam int HFILL_W = $clog2(HISTORY_DEPTH + 1);

  logic [HIDX_W-1:0]  pos_r, pos_nxt;
  logic [HFILL_W-1:0] fill_r, fill_nxt;
  logic signed [7:0]  latest_r, latest_nxt;
  logic signed [7:0]  min_r, min_nxt;
  logic signed [7:0]  max_r, max_nxt;
  logic [7:0]         rd_bits;

  always_comb begin
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    latest_nxt = latest_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    if (ctl.clear) begin
      pos_nxt    = '0;
      fill_nxt   = '0;
      latest_nxt = ctl.level;
      min_nxt    = '0;
      max_nxt    = badt_pkg::LEVEL_INIT_MAX;
    end else if (ctl.sample) begin
      latest_nxt = ctl.level;
      pos_nxt    = (pos_r == HIDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos_r + 1'b1;
      if (fill_r != HFILL_W'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
      if (ctl.level < min_r) begin
        min_nxt = ctl.level;
      end
      if (ctl.level > max_r) begin
        max_nxt = ctl.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fill_r   <= '0;
      latest_r <= '0;
      min_r    <= '0;
      max_r    <= badt_pkg::LEVEL_INIT_MAX;
    end else begin
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      latest_r <= latest_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
    end
  end

  badt_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.sample && !ctl.clear),
    .waddr (pos_r),
    .wdata (ctl.level),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign rd_level        = rd_bits;
  assign stats.ring_pos  = 7'(pos_r);
  assign stats.ring_fill = 8'(fill_r);
  assign stats.latest    = latest_r;
  assign stats.lowest    = min_r;
  assign stats.highest   = max_r;

endmodule

// ===== rtl/ble_advert_device_table_tracker.sv =====
// Top level: device table search engine, config registers and result register.
// Flow: start moves the FSM to S_EXEC, which sets the result for clear, tracking reports and
// out-of-range reads; in-range reads set it in S_READ_TBL or S_READ_HIST; a scan-mode report walks
// the table one entry per cycle over the RAM read port in S_SCAN. The result strobe is registered.
// A new start is taken in the cycle the result strobe is high; one item at a time, no stalls.
// Synchronous active-low reset empties the table and ring; no RAM clearing pass.
module ble_advert_device_table_tracker #(
  parameter int TABLE_ENTRIES = 32,
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  badt_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  output badt_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [badt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [badt_pkg::ADDR_W-1:0]          cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int HIDX_W = $clog2(HISTORY_DEPTH);
  localparam int TBL_W  = $bits(badt_pkg::tbl_entry_t);

  badt_pkg::state_t   state_r, state_nxt;
  badt_pkg::in_item_t req_r;
  badt_pkg::res_t     res_r, res_nxt;
  logic               out_valid_r, res_vld;

  logic                         mode_r;
  logic [badt_pkg::ADDR_W-1:0]  target_r;
  logic [CNT_W-1:0]             tfill_r, tfill_nxt;
  logic [CNT_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;

  logic                         tbl_we;
  logic [IDX_W-1:0]             tbl_waddr, tbl_raddr;
  badt_pkg::tbl_entry_t         tbl_wr, tbl_rd;
  logic [TBL_W-1:0]             tbl_rdata;

  badt_pkg::stats_ctl_t         sctl;
  badt_pkg::stats_t             stats;
  logic [HIDX_W-1:0]            hist_raddr;
  logic signed [7:0]            hist_level;

  assign busy      = (state_r != badt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign tbl_rd    = tbl_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      target_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == badt_pkg::REG_TRACKING_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == badt_pkg::REG_TARGET_ADDRESS) begin
        target_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    tfill_nxt    = tfill_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    tbl_we       = 1'b0;
    tbl_waddr    = cmp_idx_r;
    tbl_wr       = '{addr: req_r.device_address, level: req_r.signal_level,
                     kind: req_r.addr_kind};
    tbl_raddr    = scan_idx_r[IDX_W-1:0];
    hist_raddr   = req_r.read_index[HIDX_W-1:0];
    sctl         = '{clear: 1'b0, sample: 1'b0, level: req_r.signal_level};
    res_vld      = 1'b0;
    res_nxt      = '{status: badt_pkg::STAT_IGNORED, entry_index: '0, entry_address: '0,
                     entry_level: '0, entry_kind: '0};

    case (state_r)
      badt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = badt_pkg::S_EXEC;
        end
      end

      badt_pkg::S_EXEC: begin
        state_nxt = badt_pkg::S_IDLE;
        case (req_r.opcode)
          badt_pkg::OP_REPORT: begin
            if (mode_r) begin
              res_vld = 1'b1;
              if (req_r.device_address == target_r) begin
                sctl.sample         = 1'b1;
                res_nxt.status      = badt_pkg::STAT_SAMPLE;
                res_nxt.entry_index = stats.ring_pos;
              end
            end else begin
              scan_idx_nxt = '0;
              state_nxt    = badt_pkg::S_SCAN;
            end
          end
          badt_pkg::OP_CLEAR: begin
            tfill_nxt      = '0;
            sctl.clear     = 1'b1;
            res_vld        = 1'b1;
            res_nxt.status = badt_pkg::STAT_CLEARED;
          end
          badt_pkg::OP_READ_TBL: begin
            if (8'(req_r.read_index) < 8'(tfill_r)) begin
              tbl_raddr = req_r.read_index[IDX_W-1:0];
              state_nxt = badt_pkg::S_READ_TBL;
            end else begin
              res_vld             = 1'b1;
              res_nxt.status      = badt_pkg::STAT_READ_OOR;
              res_nxt.entry_index = req_r.read_index;
            end
          end
          badt_pkg::OP_READ_HIST: begin
            if (8'(req_r.read_index) < stats.ring_fill) begin
              state_nxt = badt_pkg::S_READ_HIST;
            end else begin
              res_vld             = 1'b1;
              res_nxt.status      = badt_pkg::STAT_READ_OOR;
              res_nxt.entry_index = req_r.read_index;
            end
          end
          default: ;
        endcase
      end

      // one read issued per cycle; the compare runs in the cycle after the read
      badt_pkg::S_SCAN: begin
        if (cmp_vld_r && (tbl_rd.addr == req_r.device_address)) begin
          tbl_we              = 1'b1;
          tbl_wr.addr         = tbl_rd.addr;
          tbl_wr.kind         = tbl_rd.kind;
          res_vld             = 1'b1;
          res_nxt.status      = badt_pkg::STAT_UPDATED;
          res_nxt.entry_index = 7'(cmp_idx_r);
          state_nxt           = badt_pkg::S_IDLE;
        end else if (scan_idx_r < tfill_r) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end else begin
          res_vld   = 1'b1;
          state_nxt = badt_pkg::S_IDLE;
          if (tfill_r < CNT_W'(TABLE_ENTRIES)) begin
            tbl_we              = 1'b1;
            tbl_waddr           = tfill_r[IDX_W-1:0];
            tfill_nxt           = tfill_r + 1'b1;
            res_nxt.status      = badt_pkg::STAT_INSERTED;
            res_nxt.entry_index = 7'(tfill_r);
          end else begin
            res_nxt.status = badt_pkg::STAT_DROPPED;
          end
        end
      end

      badt_pkg::S_READ_TBL: begin
        res_vld               = 1'b1;
        res_nxt.status        = badt_pkg::STAT_READ_OK;
        res_nxt.entry_index   = req_r.read_index;
        res_nxt.entry_address = tbl_rd.addr;
        res_nxt.entry_level   = tbl_rd.level;
        res_nxt.entry_kind    = tbl_rd.kind;
        state_nxt             = badt_pkg::S_IDLE;
      end

      badt_pkg::S_READ_HIST: begin
        res_vld             = 1'b1;
        res_nxt.status      = badt_pkg::STAT_READ_OK;
        res_nxt.entry_index = req_r.read_index;
        res_nxt.entry_level = hist_level;
        state_nxt           = badt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = badt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= badt_pkg::S_IDLE;
      tfill_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tfill_r     <= tfill_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
    if (res_vld) begin
      res_r <= res_nxt;
    end
    cmp_idx_r <= cmp_idx_nxt;
  end

  // items run strictly one after another, so a table write never meets a read
  // of the same entry in flight
  badt_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wr),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  badt_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .rd_addr  (hist_raddr),
    .rd_level (hist_level),
    .stats    (stats)
  );

  // statistics registers settle at the same edge that raises the strobe
  assign out_valid              = out_valid_r;
  assign out_data.status        = res_r.status;
  assign out_data.entry_index   = res_r.entry_index;
  assign out_data.entry_address = res_r.entry_address;
  assign out_data.entry_level   = res_r.entry_level;
  assign out_data.entry_kind    = res_r.entry_kind;
  assign out_data.devices_held  = 6'(tfill_r);
  assign out_data.current_level = stats.latest;
  assign out_data.lowest_level  = stats.lowest;
  assign out_data.highest_level = stats.highest;
  assign out_data.samples_held  = stats.ring_fill;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tfill_r <= CNT_W'(TABLE_ENTRIES))
    else $error("table fill beyond table size");

  a_sample_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == badt_pkg::STAT_SAMPLE) |-> out_data.samples_held != 8'd0)
    else $error("target sample not counted in ring fill");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the advertising device table tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import badt_pkg::*;

  localparam int TABLE_ENTRIES   = 32;
  localparam int HISTORY_DEPTH   = 128;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 194;
  localparam int CYCLE_LIMIT     = 1000000;

  // register slots the block has no use for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] TARGET_A = 48'h1234_5678_9ABC;
  localparam logic signed [7:0] LVL_MIN  = 8'sh80;
  localparam logic signed [7:0] LVL_MAX  = 8'sh7F;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [ADDR_W-1:0]    reg_val;
    in_item_t             beat;
    bit                   typed;
    out_item_t            want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  // tracker state as the testbench sees it
  bit                track_on;
  logic [ADDR_W-1:0] track_addr = '0;
  logic [ADDR_W-1:0] dev_addr [TABLE_ENTRIES];
  logic signed [7:0] dev_level [TABLE_ENTRIES];
  logic [1:0]        dev_kind [TABLE_ENTRIES];
  int                dev_count;
  logic signed [7:0] rssi_hist [HISTORY_DEPTH];
  int                hist_wr;
  int                hist_count;
  logic signed [7:0] rssi_now = '0;
  logic signed [7:0] lvl_lowest = '0;
  logic signed [7:0] lvl_highest = LEVEL_INIT_MAX;

  out_item_t   due_results [$];
  script_row_t script [$];
  int          mismatches;
  int          cycle_count;
  int          op_count [4];
  int          stat_count [8];
  int          reg_writes;
  int          ring_wraps;

  ble_advert_device_table_tracker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[ble_advert_device_table_tracker] ERROR");
      $finish;
    end
  end

  function automatic out_item_t tracker_step(in_item_t it);
    out_item_t         r;
    logic signed [7:0] lvl;
    bit                hit;
    r = '0;
    r.status = STAT_IGNORED;
    lvl = it.signal_level;
    hit = 1'b0;
    case (it.opcode)
      OP_REPORT: begin
        if (track_on) begin
          if (it.device_address == track_addr) begin
            rssi_now = lvl;
            r.entry_index = 7'(hist_wr);
            rssi_hist[hist_wr] = lvl;
            hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
            if (hist_wr == 0) ring_wraps++;
            if (hist_count < HISTORY_DEPTH) hist_count++;
            if (lvl < lvl_lowest) lvl_lowest = lvl;
            if (lvl > lvl_highest) lvl_highest = lvl;
            r.status = STAT_SAMPLE;
          end
        end else begin
          for (int i = 0; i < dev_count; i++) begin
            if (!hit && dev_addr[i] == it.device_address) begin
              dev_level[i] = lvl;
              r.status = STAT_UPDATED;
              r.entry_index = 7'(i);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (dev_count < TABLE_ENTRIES) begin
              dev_addr[dev_count] = it.device_address;
              dev_level[dev_count] = lvl;
              dev_kind[dev_count] = it.addr_kind;
              r.entry_index = 7'(dev_count);
              dev_count++;
              r.status = STAT_INSERTED;
            end else begin
              r.status = STAT_DROPPED;
            end
          end
        end
      end
      OP_CLEAR: begin
        dev_count = 0;
        hist_wr = 0;
        hist_count = 0;
        lvl_lowest = '0;
        lvl_highest = LEVEL_INIT_MAX;
        rssi_now = lvl;
        r.status = STAT_CLEARED;
      end
      OP_READ_TBL: begin
        r.entry_index = it.read_index;
        if (int'(it.read_index) < dev_count) begin
          r.entry_address = dev_addr[it.read_index];
          r.entry_level = dev_level[it.read_index];
          r.entry_kind = dev_kind[it.read_index];
          r.status = STAT_READ_OK;
        end else begin
          r.status = STAT_READ_OOR;
        end
      end
      default: begin
        r.entry_index = it.read_index;
        if (int'(it.read_index) < hist_count) begin
          r.entry_level = rssi_hist[it.read_index];
          r.status = STAT_READ_OK;
        end else begin
          r.status = STAT_READ_OOR;
        end
      end
    endcase
    r.devices_held = 6'(dev_count);
    r.current_level = rssi_now;
    r.lowest_level = lvl_lowest;
    r.highest_level = lvl_highest;
    r.samples_held = 8'(hist_count);
    return r;
  endfunction

  // result of a beat that reads nothing back
  function automatic out_item_t plain_result(status_t s, logic [6:0] ix, logic [5:0] dev,
                                             logic signed [7:0] cur, logic signed [7:0] lo,
                                             logic signed [7:0] hi, logic [7:0] samp);
    out_item_t r;
    r = '0;
    r.status = s;
    r.entry_index = ix;
    r.devices_held = dev;
    r.current_level = cur;
    r.lowest_level = lo;
    r.highest_level = hi;
    r.samples_held = samp;
    return r;
  endfunction

  function automatic void add_beat(op_t op, logic [ADDR_W-1:0] a, logic signed [7:0] l,
                                   logic [1:0] k, logic [6:0] ri, bit typed = 1'b0,
                                   out_item_t want = '0);
    script_row_t row;
    row = '{default: '0};
    row.beat.opcode = op;
    row.beat.device_address = a;
    row.beat.signal_level = l;
    row.beat.addr_kind = k;
    row.beat.read_index = ri;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_beat(in_item_t beat, bit typed, out_item_t want);
    out_item_t predicted;
    start <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = tracker_step(beat);
    due_results.push_back(typed ? want : predicted);
    op_count[beat.opcode]++;
  endtask

  task automatic pause_sender(bit allow);
    int p;
    int n;
    p = $urandom_range(0, 99);
    n = 0;
    if (allow && p >= 50) begin
      if (p < 82) n = $urandom_range(1, 3);
      else if (p < 97) n = $urandom_range(4, 15);
      else n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every pending result is back
  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_TRACKING_MODE) track_on = val[0];
    else if (idx == REG_TARGET_ADDRESS) track_addr = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic check_result(out_item_t want, out_item_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.entry_index !== want.entry_index) begin
      $error("entry_index: expected %0d got %0d", want.entry_index, got.entry_index);
      mismatches++;
    end
    if (got.entry_address !== want.entry_address) begin
      $error("entry_address: expected %h got %h", want.entry_address, got.entry_address);
      mismatches++;
    end
    if (got.entry_level !== want.entry_level) begin
      $error("entry_level: expected %0d got %0d", want.entry_level, got.entry_level);
      mismatches++;
    end
    if (got.entry_kind !== want.entry_kind) begin
      $error("entry_kind: expected %0d got %0d", want.entry_kind, got.entry_kind);
      mismatches++;
    end
    if (got.devices_held !== want.devices_held) begin
      $error("devices_held: expected %0d got %0d", want.devices_held, got.devices_held);
      mismatches++;
    end
    if (got.current_level !== want.current_level) begin
      $error("current_level: expected %0d got %0d", want.current_level, got.current_level);
      mismatches++;
    end
    if (got.lowest_level !== want.lowest_level) begin
      $error("lowest_level: expected %0d got %0d", want.lowest_level, got.lowest_level);
      mismatches++;
    end
    if (got.highest_level !== want.highest_level) begin
      $error("highest_level: expected %0d got %0d", want.highest_level, got.highest_level);
      mismatches++;
    end
    if (got.samples_held !== want.samples_held) begin
      $error("samples_held: expected %0d got %0d", want.samples_held, got.samples_held);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("status: expected none got %0d (result with no beat pending)", out_data.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_result(want, out_data);
        stat_count[want.status]++;
      end
    end
  end

  initial begin
    in_item_t it;
    int       p;
    int       top;
    bit       no_idle;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    // empty block, then the address and level extremes in scan mode
    add_beat(OP_READ_TBL, '0, '0, 2'd0, 7'd0, 1'b1,
             plain_result(STAT_READ_OOR, 7'd0, 6'd0, '0, '0, LEVEL_INIT_MAX, 8'd0));
    add_beat(OP_READ_HIST, ALL_ONES, LVL_MAX, 2'd3, 7'd127, 1'b1,
             plain_result(STAT_READ_OOR, 7'd127, 6'd0, '0, '0, LEVEL_INIT_MAX, 8'd0));
    add_beat(OP_REPORT, '0, LVL_MIN, 2'd0, 7'd0, 1'b1,
             plain_result(STAT_INSERTED, 7'd0, 6'd1, '0, '0, LEVEL_INIT_MAX, 8'd0));
    add_beat(OP_REPORT, ALL_ONES, LVL_MAX, 2'd3, 7'd127, 1'b1,
             plain_result(STAT_INSERTED, 7'd1, 6'd2, '0, '0, LEVEL_INIT_MAX, 8'd0));
    add_beat(OP_REPORT, '0, 8'sd5, 2'd2, 7'd0);
    add_beat(OP_READ_TBL, '0, '0, 2'd0, 7'd1);
    add_beat(OP_READ_TBL, '0, '0, 2'd0, 7'd0);
    add_beat(OP_READ_TBL, '0, '0, 2'd0, 7'd2);
    add_beat(OP_CLEAR, ALL_ONES, LVL_MIN, 2'd3, 7'd127, 1'b1,
             plain_result(STAT_CLEARED, 7'd0, 6'd0, LVL_MIN, '0, LEVEL_INIT_MAX, 8'd0));
    // tracking: near-miss address is ignored, then both level extremes
    add_write(REG_TRACKING_MODE, 48'd1);
    add_write(REG_TARGET_ADDRESS, TARGET_A);
    add_beat(OP_REPORT, TARGET_A ^ 48'd1, 8'sd9, 2'd1, 7'd0, 1'b1,
             plain_result(STAT_IGNORED, 7'd0, 6'd0, LVL_MIN, '0, LEVEL_INIT_MAX, 8'd0));
    add_beat(OP_REPORT, TARGET_A, LVL_MAX, 2'd1, 7'd0);
    add_beat(OP_REPORT, TARGET_A, LVL_MIN, 2'd0, 7'd0);
    add_beat(OP_READ_HIST, '0, '0, 2'd0, 7'd0);
    add_beat(OP_READ_HIST, '0, '0, 2'd0, 7'd1);
    add_beat(OP_READ_HIST, '0, '0, 2'd0, 7'd2);
    add_beat(OP_READ_TBL, '0, '0, 2'd0, 7'd0);
    // spare slots are dropped; mode only looks at bit 0
    add_write(REG_SPARE_2, ALL_ONES);
    add_write(REG_SPARE_3, ALL_ONES);
    add_write(REG_TRACKING_MODE, 48'hFFFF_FFFF_FFFE);
    add_beat(OP_REPORT, TARGET_A, '0, 2'd2, 7'd0);
    add_beat(OP_CLEAR, '0, LVL_MAX, 2'd0, 7'd0, 1'b1,
             plain_result(STAT_CLEARED, 7'd0, 6'd0, LVL_MAX, '0, LEVEL_INIT_MAX, 8'd0));
    add_write(REG_TARGET_ADDRESS, ALL_ONES);
    add_write(REG_TRACKING_MODE, ALL_ONES);
    add_beat(OP_REPORT, ALL_ONES, '0, 2'd3, 7'd0);
    add_beat(OP_READ_HIST, '0, '0, 2'd0, 7'd0);
    add_write(REG_TARGET_ADDRESS, '0);
    add_beat(OP_REPORT, '0, 8'shFF, 2'd0, 7'd0);
    add_beat(OP_REPORT, ALL_ONES, '0, 2'd0, 7'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        drain();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_beat(script[i].beat, script[i].typed, script[i].want);
        pause_sender(1'b1);
      end
    end

    // random phases: scan and tracking alternate; target cycles zero, all ones, random
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ((ph / 2) % 3)
        0: write_reg(REG_TARGET_ADDRESS, '0);
        1: write_reg(REG_TARGET_ADDRESS, ALL_ONES);
        default: write_reg(REG_TARGET_ADDRESS, rand_addr());
      endcase
      write_reg(REG_TRACKING_MODE, 48'(ph % 2));
      no_idle = (ph % 3 == 2);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        it.opcode = OP_REPORT;
        it.device_address = rand_addr();
        it.signal_level = 8'($urandom);
        it.addr_kind = 2'($urandom);
        it.read_index = 7'($urandom);
        p = $urandom_range(0, 99);
        top = (hist_count > 127) ? 127 : hist_count;
        if (!track_on) begin
          // clear mostly once the table is full, so drops get exercised first
          if ((dev_count == TABLE_ENTRIES && p < 4) || p == 99) begin
            it.opcode = OP_CLEAR;
          end else if (p < 75) begin
            if (dev_count > 0 && $urandom_range(0, 99) < 40)
              it.device_address = dev_addr[$urandom_range(0, dev_count - 1)];
          end else if (p < 90) begin
            it.opcode = OP_READ_TBL;
            if ($urandom_range(0, 3) != 0) it.read_index = 7'($urandom_range(0, dev_count));
          end else begin
            it.opcode = OP_READ_HIST;
            if ($urandom_range(0, 3) != 0) it.read_index = 7'($urandom_range(0, top));
          end
        end else begin
          if ((hist_count == HISTORY_DEPTH && p < 3) || p == 99) begin
            it.opcode = OP_CLEAR;
          end else if (p < 70) begin
            it.device_address = track_addr;
          end else if (p < 78) begin
            if ($urandom_range(0, 1))
              it.device_address = track_addr ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
          end else if (p < 92) begin
            it.opcode = OP_READ_HIST;
            if ($urandom_range(0, 3) != 0) it.read_index = 7'($urandom_range(0, top));
          end else begin
            it.opcode = OP_READ_TBL;
            if ($urandom_range(0, 3) != 0) it.read_index = 7'($urandom_range(0, dev_count));
          end
        end
        send_beat(it, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain();
        else pause_sender(!no_idle);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("status: %0d results never arrived", due_results.size());
      mismatches++;
    end
    $display("covered %0d beats (reports %0d, clears %0d, table reads %0d, history reads %0d),",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0], op_count[1],
             op_count[2], op_count[3]);
    $display("  %0d register writes, %0d ring wraps; outcomes upd %0d ins %0d drop %0d",
             reg_writes, ring_wraps, stat_count[0], stat_count[1], stat_count[2]);
    $display("  ign %0d smp %0d clr %0d rd %0d oor %0d",
             stat_count[3], stat_count[4], stat_count[5], stat_count[6], stat_count[7]);
    if (mismatches == 0) begin
      $display("[ble_advert_device_table_tracker] OK");
    end else begin
      $display("[ble_advert_device_table_tracker] ERROR");
    end
    $finish;
  end

endmodule
